FILE: hw/rtl/sexpr_token_lexer_macros.svh
// ------------------------------------------------------------------------
// S-expression lexer assertion macros
// Shared concurrent assertion forms for the lexer checker.
// ------------------------------------------------------------------------
`ifndef SEXPR_TOKEN_LEXER_MACROS_SVH
`define SEXPR_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLX_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sexpr lexer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SLX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sexpr lexer: next-cycle check failed");

`endif

FILE: hw/rtl/slx_pkg.sv
// ------------------------------------------------------------------------
// S-expression lexer package
// Types, codes and character classes shared by the lexer modules.
// ------------------------------------------------------------------------
package slx_pkg;

   localparam int LINE_BITS = 16;

   // lexer modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_LEAD    = 3'd2;
   localparam logic [2:0] MODE_NUMBER  = 3'd3;
   localparam logic [2:0] MODE_STRING  = 3'd4;
   localparam logic [2:0] MODE_ESC     = 3'd5;
   localparam logic [2:0] MODE_SYMBOL  = 3'd6;

   // token classes
   localparam logic [3:0] CL_NONE   = 4'd0;
   localparam logic [3:0] CL_OPEN   = 4'd1;
   localparam logic [3:0] CL_CLOSE  = 4'd2;
   localparam logic [3:0] CL_QUOTE  = 4'd3;
   localparam logic [3:0] CL_COMMA  = 4'd4;
   localparam logic [3:0] CL_DOT    = 4'd5;
   localparam logic [3:0] CL_INT    = 4'd6;
   localparam logic [3:0] CL_FLOAT  = 4'd7;
   localparam logic [3:0] CL_STRING = 4'd8;
   localparam logic [3:0] CL_SYMBOL = 4'd9;

   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // characters
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef struct packed {
      logic       kind;
      logic [3:0] cls;
      logic [7:0] ch;
   } item_type;

   typedef struct packed {
      logic [1:0] n;
      item_type   it2;
      item_type   it1;
      item_type   it0;
   } result_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] lead;
      logic       num_int;
   } lex_state_type;

   typedef struct packed {
      logic          has;
      item_type      it;
      lex_state_type st;
   } start_type;

   function automatic logic is_white(input logic [7:0] c);
      return c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_FF ||
             c == CH_CR || c == CH_SPACE;
   endfunction

   function automatic logic is_break(input logic [7:0] c);
      return is_white(c) || c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN ||
             c == CH_SQUOTE || c == CH_COMMA;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_numchar(input logic [7:0] c);
      return is_digit(c) || c == CH_DOT || c == CH_MINUS || c == CH_PLUS;
   endfunction

   function automatic item_type text_item(input logic [7:0] c);
      item_type it;
      it.kind = KIND_TEXT;
      it.cls  = CL_NONE;
      it.ch   = c;
      return it;
   endfunction

   function automatic item_type done_item(input logic [3:0] cls);
      item_type it;
      it.kind = KIND_DONE;
      it.cls  = cls;
      it.ch   = 8'd0;
      return it;
   endfunction

endpackage

FILE: hw/rtl/slx_step.sv
// ------------------------------------------------------------------------
// S-expression lexer step logic
// Next lexer state and up to three results for one source byte.
// ------------------------------------------------------------------------
module slx_step import slx_pkg::*; (
   input  lex_state_type state,
   input  logic [7:0]    char_in,
   input  logic          end_of_input,
   output lex_state_type state_in,
   output result_type    res
);

   logic [2:0]    mode;
   lex_state_type start_st;
   start_type     sn;
   logic [3:0]    num_cls;
   logic          brk;

   // byte seen with no token open
   function automatic start_type start_tok(input logic [7:0] c, input lex_state_type s);
      start_type r;
      r.has        = 1'b0;
      r.it         = text_item(c);
      r.st         = s;
      r.st.mode    = MODE_IDLE;
      if (!is_white(c)) begin
         case (c) inside
            CH_SEMI:   r.st.mode = MODE_COMMENT;
            CH_LPAREN: begin r.has = 1'b1; r.it = done_item(CL_OPEN);  end
            CH_RPAREN: begin r.has = 1'b1; r.it = done_item(CL_CLOSE); end
            CH_SQUOTE: begin r.has = 1'b1; r.it = done_item(CL_QUOTE); end
            CH_COMMA:  begin r.has = 1'b1; r.it = done_item(CL_COMMA); end
            CH_DOT, CH_PLUS, CH_MINUS: begin
               r.st.lead = c;
               r.st.mode = MODE_LEAD;
            end
            CH_DQUOTE: r.st.mode = MODE_STRING;
            default: begin
               r.has = 1'b1;
               if (is_digit(c)) begin
                  r.st.num_int = 1'b1;
                  r.st.mode    = MODE_NUMBER;
               end else begin
                  r.st.mode = MODE_SYMBOL;
               end
            end
         endcase
      end
      return r;
   endfunction

   always_comb begin
      mode        = (state.mode > MODE_SYMBOL) ? MODE_IDLE : state.mode;
      start_st    = state;
      start_st.mode = mode;
      sn          = start_tok(char_in, start_st);
      num_cls     = state.num_int ? CL_INT : CL_FLOAT;
      brk         = is_break(char_in);
      state_in    = start_st;
      res.n       = 2'd0;
      res.it0     = done_item(CL_NONE);
      res.it1     = done_item(CL_NONE);
      res.it2     = done_item(CL_NONE);

      if (end_of_input) begin
         state_in.mode = MODE_IDLE;
         unique case (mode)
            MODE_LEAD: begin
               if (state.lead == CH_DOT) begin
                  res.n = 2'd1; res.it0 = done_item(CL_DOT);
               end else begin
                  res.n = 2'd2; res.it0 = text_item(state.lead);
                  res.it1 = done_item(CL_SYMBOL);
               end
            end
            MODE_NUMBER: begin res.n = 2'd1; res.it0 = done_item(num_cls); end
            MODE_STRING, MODE_ESC: begin
               res.n = 2'd1; res.it0 = done_item(CL_STRING);
            end
            MODE_SYMBOL: begin res.n = 2'd1; res.it0 = done_item(CL_SYMBOL); end
            default: ;
         endcase
      end else begin
         unique case (mode)
            MODE_COMMENT: begin
               if (char_in == CH_NL) state_in.mode = MODE_IDLE;
            end
            MODE_LEAD: begin
               if (state.lead == CH_DOT && brk) begin
                  state_in = sn.st;
                  res.n    = sn.has ? 2'd2 : 2'd1;
                  res.it0  = done_item(CL_DOT);
                  res.it1  = sn.it;
               end else if (is_digit(char_in)) begin
                  state_in.num_int = (state.lead != CH_DOT);
                  state_in.mode    = MODE_NUMBER;
                  res.n   = 2'd2;
                  res.it0 = text_item(state.lead);
                  res.it1 = text_item(char_in);
               end else if (brk) begin
                  state_in = sn.st;
                  res.n    = sn.has ? 2'd3 : 2'd2;
                  res.it0  = text_item(state.lead);
                  res.it1  = done_item(CL_SYMBOL);
                  res.it2  = sn.it;
               end else begin
                  state_in.mode = MODE_SYMBOL;
                  res.n   = 2'd2;
                  res.it0 = text_item(state.lead);
                  res.it1 = text_item(char_in);
               end
            end
            MODE_NUMBER: begin
               if (is_numchar(char_in)) begin
                  if (char_in == CH_DOT) state_in.num_int = 1'b0;
                  res.n = 2'd1; res.it0 = text_item(char_in);
               end else if (brk) begin
                  state_in = sn.st;
                  res.n    = sn.has ? 2'd2 : 2'd1;
                  res.it0  = done_item(num_cls);
                  res.it1  = sn.it;
               end else begin
                  state_in.mode = MODE_SYMBOL;
                  res.n = 2'd1; res.it0 = text_item(char_in);
               end
            end
            MODE_STRING: begin
               if (char_in == CH_DQUOTE) begin
                  state_in.mode = MODE_IDLE;
                  res.n = 2'd1; res.it0 = done_item(CL_STRING);
               end else begin
                  if (char_in == CH_BSLASH) state_in.mode = MODE_ESC;
                  res.n = 2'd1; res.it0 = text_item(char_in);
               end
            end
            MODE_ESC: begin
               state_in.mode = MODE_STRING;
               res.n = 2'd1; res.it0 = text_item(char_in);
            end
            MODE_SYMBOL: begin
               if (brk) begin
                  state_in = sn.st;
                  res.n    = sn.has ? 2'd2 : 2'd1;
                  res.it0  = done_item(CL_SYMBOL);
                  res.it1  = sn.it;
               end else begin
                  res.n = 2'd1; res.it0 = text_item(char_in);
               end
            end
            default: begin
               state_in = sn.st;
               res.n    = sn.has ? 2'd1 : 2'd0;
               res.it0  = sn.it;
            end
         endcase
      end
   end

endmodule

FILE: hw/rtl/slx_queue.sv
// ------------------------------------------------------------------------
// S-expression lexer result buffer
// Holds the results of one byte and hands them out one per cycle while rsp_stall is low.
// ------------------------------------------------------------------------
module slx_queue import slx_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  result_type    res,
   input  logic [15:0]   line_in,
   output logic          ready,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_item_kind,
   output logic [3:0]    rsp_token_class,
   output logic [7:0]    rsp_char_out,
   output logic [15:0]   rsp_line_number,
   output logic          rsp_last_of_run
);

   item_type    items_ff [3];
   logic [1:0]  cnt_ff;
   logic [1:0]  head_ff;
   logic [15:0] line_ff;
   logic        take;
   item_type    cur;

   assign take  = rsp_valid && !rsp_stall;
   assign ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && !rsp_stall);
   assign cur   = items_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         head_ff <= 2'd0;
      end else if (load) begin
         cnt_ff  <= res.n;
         head_ff <= 2'd0;
      end else if (take) begin
         cnt_ff  <= cnt_ff - 2'd1;
         head_ff <= head_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         items_ff[0] <= res.it0;
         items_ff[1] <= res.it1;
         items_ff[2] <= res.it2;
         line_ff     <= line_in;
      end
   end

   assign rsp_valid       = cnt_ff != 2'd0;
   assign rsp_item_kind   = cur.kind;
   assign rsp_token_class = cur.cls;
   assign rsp_char_out    = cur.ch;
   assign rsp_line_number = line_ff;
   assign rsp_last_of_run = cnt_ff == 2'd1;

endmodule

FILE: hw/rtl/sexpr_token_lexer.sv
// ------------------------------------------------------------------------
// S-expression token lexer
// Takes one source byte per transaction (or an end-of-input mark) and
// returns token text bytes and completed tokens with their class and the
// newline count. A byte is taken in the cycle it arrives when the buffer
// is ready, and its results are registered in a three-entry buffer that
// hands out one result per cycle unless rsp_stall holds it; the next byte
// is taken in the cycle the last result of the previous one leaves, or
// while the buffer is empty.
// ------------------------------------------------------------------------
module sexpr_token_lexer import slx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic [3:0]  rsp_token_class,
   output logic [7:0]  rsp_char_out,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last_of_run
);

   lex_state_type        state_ff, state_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   result_type           res;
   logic                 ready;
   logic                 accept;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;
   assign line_in   = (!req_end_of_input && req_char_in == CH_NL) ?
                      line_ff + LINE_BITS'(1) : line_ff;

   slx_step u_step (
      .state        (state_ff),
      .char_in      (req_char_in),
      .end_of_input (req_end_of_input),
      .state_in     (state_in),
      .res          (res)
   );

   slx_queue u_queue (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .res             (res),
      .line_in         (16'(line_ff)),
      .ready           (ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item_kind   (rsp_item_kind),
      .rsp_token_class (rsp_token_class),
      .rsp_char_out    (rsp_char_out),
      .rsp_line_number (rsp_line_number),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode    <= MODE_IDLE;
         state_ff.lead    <= 8'd0;
         state_ff.num_int <= 1'b1;
         line_ff          <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         line_ff  <= line_in;
      end
   end

endmodule

FILE: hw/rtl/slx_checker.sv
// ------------------------------------------------------------------------
// S-expression lexer port checker
// Watches the result channel for malformed or inconsistent results.
// ------------------------------------------------------------------------
`include "sexpr_token_lexer_macros.svh"

module slx_checker import slx_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_item_kind,
   input logic [3:0]  rsp_token_class,
   input logic [7:0]  rsp_char_out,
   input logic [15:0] rsp_line_number,
   input logic        rsp_last_of_run
);

   `SLX_ASSERT_IMPLY(a_text_no_class, clock, reset,
      rsp_valid && rsp_item_kind == KIND_TEXT, rsp_token_class == CL_NONE)
   `SLX_ASSERT_IMPLY(a_done_no_char, clock, reset,
      rsp_valid && rsp_item_kind == KIND_DONE, rsp_char_out == 8'd0)
   `SLX_ASSERT_IMPLY(a_done_class, clock, reset,
      rsp_valid && rsp_item_kind == KIND_DONE,
      rsp_token_class != CL_NONE && rsp_token_class <= CL_SYMBOL)
   `SLX_ASSERT_NEXT(a_run_continues, clock, reset,
      rsp_valid && !rsp_stall && !rsp_last_of_run,
      rsp_valid && $stable(rsp_line_number))

endmodule

bind sexpr_token_lexer slx_checker u_slx_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// S-expression token lexer testbench
// Feeds source bytes and end-of-input marks to the lexer through named
// test tasks, predicts the token text and completed-token results with an
// in-bench scanner, and checks every result transaction field by field.
// Covers punctuation, signed numbers, leads, strings with escapes,
// comments, end-of-input closes, random source text with idling on both
// sides, and a long receiver hold-off.
// ------------------------------------------------------------------------
module tb import slx_pkg::*; ();

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      item_type    it;
      logic [15:0] line;
      logic        last;
   } lexeme_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'd0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_item_kind;
   logic [3:0]  rsp_token_class;
   logic [7:0]  rsp_char_out;
   logic [15:0] rsp_line_number;
   logic        rsp_last_of_run;

   // scanner state
   logic [2:0]  scan_mode = MODE_IDLE;
   logic [7:0]  scan_lead = 8'd0;
   logic        scan_is_int = 1'b1;
   logic [15:0] scan_lines = 16'd0;
   item_type    step_items[$];

   lexeme_type  expected_lexemes[$];
   logic [8:0]  src_text[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int n_sent = 0;
   int n_results = 0;
   int n_tokens = 0;
   int n_errors = 0;

   sexpr_token_lexer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_token_class  (rsp_token_class),
      .rsp_char_out     (rsp_char_out),
      .rsp_line_number  (rsp_line_number),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time,
                  expected_lexemes.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- scanner
   function automatic logic space_char(input logic [7:0] c);
      return c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_FF ||
             c == CH_CR || c == CH_SPACE;
   endfunction

   function automatic logic delim_char(input logic [7:0] c);
      return space_char(c) || c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN ||
             c == CH_SQUOTE || c == CH_COMMA;
   endfunction

   function automatic logic dec_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void add_text(input logic [7:0] c);
      step_items.push_back('{kind: KIND_TEXT, cls: CL_NONE, ch: c});
   endfunction

   function automatic void add_done(input logic [3:0] cls);
      step_items.push_back('{kind: KIND_DONE, cls: cls, ch: 8'd0});
   endfunction

   function automatic void open_token(input logic [7:0] c);
      scan_mode = MODE_IDLE;
      if (space_char(c))
         return;
      case (c)
         CH_SEMI:   scan_mode = MODE_COMMENT;
         CH_LPAREN: add_done(CL_OPEN);
         CH_RPAREN: add_done(CL_CLOSE);
         CH_SQUOTE: add_done(CL_QUOTE);
         CH_COMMA:  add_done(CL_COMMA);
         CH_DOT, CH_PLUS, CH_MINUS: begin
            scan_lead = c;
            scan_mode = MODE_LEAD;
         end
         CH_DQUOTE: scan_mode = MODE_STRING;
         default: begin
            add_text(c);
            if (dec_digit(c)) begin
               scan_is_int = 1'b1;
               scan_mode = MODE_NUMBER;
            end else begin
               scan_mode = MODE_SYMBOL;
            end
         end
      endcase
   endfunction

   function automatic void close_at_end();
      case (scan_mode)
         MODE_LEAD: begin
            if (scan_lead == CH_DOT) begin
               add_done(CL_DOT);
            end else begin
               add_text(scan_lead);
               add_done(CL_SYMBOL);
            end
         end
         MODE_NUMBER:          add_done(scan_is_int ? CL_INT : CL_FLOAT);
         MODE_STRING, MODE_ESC: add_done(CL_STRING);
         MODE_SYMBOL:          add_done(CL_SYMBOL);
         default: ;
      endcase
      scan_mode = MODE_IDLE;
   endfunction

   function automatic void feed_byte(input logic [7:0] c);
      case (scan_mode)
         MODE_COMMENT: begin
            if (c == CH_NL)
               scan_mode = MODE_IDLE;
         end
         MODE_LEAD: begin
            if (scan_lead == CH_DOT && delim_char(c)) begin
               add_done(CL_DOT);
               open_token(c);
            end else if (dec_digit(c)) begin
               scan_is_int = (scan_lead != CH_DOT);
               add_text(scan_lead);
               add_text(c);
               scan_mode = MODE_NUMBER;
            end else begin
               add_text(scan_lead);
               if (delim_char(c)) begin
                  add_done(CL_SYMBOL);
                  open_token(c);
               end else begin
                  add_text(c);
                  scan_mode = MODE_SYMBOL;
               end
            end
         end
         MODE_NUMBER: begin
            if (dec_digit(c) || c == CH_DOT || c == CH_MINUS || c == CH_PLUS) begin
               if (c == CH_DOT)
                  scan_is_int = 1'b0;
               add_text(c);
            end else if (delim_char(c)) begin
               add_done(scan_is_int ? CL_INT : CL_FLOAT);
               open_token(c);
            end else begin
               add_text(c);
               scan_mode = MODE_SYMBOL;
            end
         end
         MODE_STRING: begin
            if (c == CH_DQUOTE) begin
               add_done(CL_STRING);
               scan_mode = MODE_IDLE;
            end else begin
               add_text(c);
               if (c == CH_BSLASH)
                  scan_mode = MODE_ESC;
            end
         end
         MODE_ESC: begin
            add_text(c);
            scan_mode = MODE_STRING;
         end
         MODE_SYMBOL: begin
            if (delim_char(c)) begin
               add_done(CL_SYMBOL);
               open_token(c);
            end else begin
               add_text(c);
            end
         end
         default: open_token(c);
      endcase
   endfunction

   function automatic void predict_lexemes(input logic [7:0] c, input logic eoi);
      logic [15:0] line_now;
      lexeme_type  rec;
      line_now = scan_lines;
      step_items.delete();
      if (scan_mode > MODE_SYMBOL)
         scan_mode = MODE_IDLE;
      if (eoi) begin
         close_at_end();
      end else begin
         feed_byte(c);
         if (c == CH_NL)
            scan_lines = scan_lines + 16'd1;
      end
      foreach (step_items[i]) begin
         rec.it = step_items[i];
         rec.line = line_now;
         rec.last = (i == step_items.size() - 1);
         expected_lexemes.push_back(rec);
      end
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      lexeme_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (rsp_item_kind == KIND_DONE)
            n_tokens++;
         if (expected_lexemes.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result, expected none actual kind %b class %0d",
                     $time, rsp_item_kind, rsp_token_class);
         end else begin
            want = expected_lexemes.pop_front();
            check_field("item_kind", 16'(want.it.kind), 16'(rsp_item_kind));
            check_field("token_class", 16'(want.it.cls), 16'(rsp_token_class));
            check_field("char_out", 16'(want.it.ch), 16'(rsp_char_out));
            check_field("line_number", want.line, rsp_line_number);
            check_field("last_of_run", 16'(want.last), 16'(rsp_last_of_run));
         end
      end
   end

   // receiver: random stall, or a counted hold-off on request
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic send_byte(input logic [7:0] c, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_char_in <= c;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_stall);
      predict_lexemes(c, eoi);
      n_sent++;
   endtask

   task automatic send_text();
      logic [8:0] b;
      while (src_text.size() > 0) begin
         b = src_text.pop_front();
         send_byte(b[7:0], b[8]);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_lexemes.size() != 0)
         @(posedge clock);
   endtask

   function automatic void put_byte(input logic [7:0] c);
      src_text.push_back({1'b0, c});
   endfunction

   function automatic void put_end();
      src_text.push_back({1'b1, 8'($urandom_range(255))});
   endfunction

   function automatic void put_str(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         put_byte(s[i]);
   endfunction

   function automatic logic [7:0] pick_space();
      case ($urandom_range(5))
         0:       return CH_TAB;
         1:       return CH_NL;
         2:       return CH_VT;
         3:       return CH_FF;
         4:       return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] pick_digit();
      return CH_ZERO + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] pick_sym_char();
      case ($urandom_range(3))
         0:       return 8'h61 + 8'($urandom_range(25));
         1:       return 8'h41 + 8'($urandom_range(25));
         2:       return 8'h3C + 8'($urandom_range(3));
         default: return 8'h80 + 8'($urandom_range(127));
      endcase
   endfunction

   function automatic logic [7:0] pick_break();
      case ($urandom_range(4))
         0:       return CH_LPAREN;
         1:       return CH_RPAREN;
         2:       return CH_SQUOTE;
         3:       return CH_COMMA;
         default: return pick_space();
      endcase
   endfunction

   function automatic logic [7:0] pick_lead();
      case ($urandom_range(2))
         0:       return CH_DOT;
         1:       return CH_PLUS;
         default: return CH_MINUS;
      endcase
   endfunction

   function automatic void put_digits(input int n);
      int i;
      for (i = 0; i < n; i++)
         put_byte(pick_digit());
   endfunction

   // one random piece of source text, mostly well-formed tokens
   function automatic void gen_fragment();
      int         i;
      int         n;
      logic [7:0] c;
      case ($urandom_range(19))
         0, 1: begin
            case ($urandom_range(3))
               0:       put_byte(CH_LPAREN);
               1:       put_byte(CH_RPAREN);
               2:       put_byte(CH_SQUOTE);
               default: put_byte(CH_COMMA);
            endcase
         end
         2, 3: begin
            if ($urandom_range(2) == 0)
               put_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
            put_digits(1 + $urandom_range(3));
         end
         4, 5: begin
            if ($urandom_range(1)) begin
               put_byte(CH_DOT);
               put_digits(1 + $urandom_range(2));
            end else begin
               if ($urandom_range(2) == 0)
                  put_byte(CH_MINUS);
               put_digits(1 + $urandom_range(2));
               put_byte(CH_DOT);
               put_digits($urandom_range(2));
            end
         end
         6, 7: begin
            n = 1 + $urandom_range(4);
            for (i = 0; i < n; i++)
               put_byte(i > 0 && $urandom_range(3) == 0 ? pick_digit() : pick_sym_char());
         end
         8, 9: begin
            put_byte(CH_DQUOTE);
            n = $urandom_range(5);
            for (i = 0; i < n; i++) begin
               case ($urandom_range(4))
                  0: begin
                     put_byte(CH_BSLASH);
                     put_byte(8'($urandom_range(255)));
                  end
                  1:       put_byte(CH_NL);
                  default: put_byte(8'h20 + 8'($urandom_range(94)));
               endcase
            end
            if ($urandom_range(4) == 0)
               put_end();
            else
               put_byte(CH_DQUOTE);
         end
         10: begin
            put_byte(CH_SEMI);
            n = $urandom_range(6);
            for (i = 0; i < n; i++) begin
               c = 8'($urandom_range(255));
               put_byte(c == CH_NL ? CH_SPACE : c);
            end
            put_byte(CH_NL);
         end
         11, 12: begin
            put_byte(pick_lead());
            case ($urandom_range(2))
               0:       put_byte(pick_break());
               1:       put_byte(pick_sym_char());
               default: put_byte(pick_lead());
            endcase
         end
         13: begin
            put_digits(1 + $urandom_range(2));
            put_byte(pick_sym_char());
            if ($urandom_range(1))
               put_byte(pick_digit());
         end
         14, 15: begin
            n = 1 + $urandom_range(2);
            for (i = 0; i < n; i++)
               put_byte(8'($urandom_range(255)));
         end
         16: put_end();
         17: begin
            put_byte(pick_lead());
            put_end();
         end
         default: begin
            n = 1 + $urandom_range(2);
            for (i = 0; i < n; i++)
               put_byte(pick_space());
         end
      endcase
      if ($urandom_range(9) < 6)
         put_byte(pick_space());
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_punctuation();
      put_str("',");
      send_text();
   endtask

   task automatic test_numbers_and_leads();
      // signed float to symbol, dot before break, lead before comma, float closed by paren
      put_str("+5.7a .(-,-7 .5)");
      send_text();
   endtask

   task automatic test_strings();
      // escaped quote and a raw newline, left open at end of input
      put_str("\"a\\\"\n");
      put_end();
      send_text();
   endtask

   task automatic test_comments_and_ends();
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(CH_SEMI);
      put_end();
      put_byte(CH_PLUS);
      put_end();
      put_byte(CH_DOT);
      put_end();
      put_end();
      send_text();
   endtask

   task automatic test_random_stream(input int send_pct, input int recv_pct,
                                     input int n_items);
      int start;
      start = n_sent;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (n_sent - start < n_items) begin
         gen_fragment();
         send_text();
      end
      put_end();
      send_text();
      wait_drained();
   endtask

   task automatic test_backpressure();
      int i;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 60;
      for (i = 0; i < 8; i++)
         put_str("-,x");
      put_end();
      send_text();
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 22;
      recv_idle_pct = 49;
      test_punctuation();
      test_numbers_and_leads();
      test_strings();
      test_comments_and_ends();
      wait_drained();

      test_random_stream(22, 49, 35);
      test_random_stream(49, 22, 35);
      test_random_stream(0, 0, 35);
      test_backpressure();

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d source transactions, checked %0d results including %0d tokens,",
               n_sent, n_results, n_tokens);
      $display("across punctuation, numbers, leads, strings, comments and a long hold-off.");
      if (n_errors == 0 && expected_lexemes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", n_errors,
                  expected_lexemes.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/slx_pkg.sv
hw/rtl/slx_step.sv
hw/rtl/slx_queue.sv
hw/rtl/sexpr_token_lexer.sv
hw/rtl/slx_checker.sv
tb/tb.sv
